[rtl/colpt_pkg.sv]
package colpt_pkg;

    localparam int S_TDATA_W = 352;
    localparam int M_TDATA_W = 128;

    localparam logic [1:0] KIND_SPHERE = 2'd0;
    localparam logic [1:0] KIND_BOX    = 2'd1;
    localparam logic [1:0] KIND_PLANE  = 2'd2;
    localparam logic [1:0] KIND_POINT  = 2'd3;

    localparam logic [30:0] POINT_MARGIN_RST = 31'd6554;

    typedef enum logic [2:0] {
        OP_NONE = 3'd0,
        OP_SS   = 3'd1,
        OP_SP   = 3'd2,
        OP_SPL  = 3'd3,
        OP_PPL  = 3'd4,
        OP_BS   = 3'd5,
        OP_BPL  = 3'd6
    } op_t;

    // per-item data carried alongside the arithmetic pipe ahead of the square root
    typedef struct packed {
        op_t                     op;
        logic [2:0][31:0]        n;
        logic signed [31:0]      r;
        logic signed [31:0]      d;
        logic signed [32:0]      rlim;
        logic [2:0][32:0]        diff;
        logic                    eovf;
        logic [2:0][31:0]        face;
    } side_t;

    // per-item data carried through the square root and divider
    typedef struct packed {
        op_t                     op;
        logic                    hit;
        logic [2:0][31:0]        n;
        logic signed [31:0]      push;
        logic [2:0][32:0]        diff;
        logic signed [32:0]      rlim;
    } ctx_t;

    function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
        logic signed [67:0] hi;
        logic signed [67:0] lo;
        hi = 68'sd2147483647;
        lo = -68'sd2147483648;
        if (v > hi) begin
            return 32'sh7fffffff;
        end else if (v < lo) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

endpackage

[rtl/collision_pair_test_unit.sv]
// Narrow-phase collision test, one object pair per transaction. s_tuser carries the
// pair code (4*kind_a + kind_b; 0 sphere, 1 box, 2 plane, 3 point); the unit orders
// the pair, tests for contact and returns hit in m_tuser with the contact normal and
// push depth in m_tdata, all signed fixed point with FRAC_BITS fraction bits (Q16.16
// by default) and saturated to 32 bits. Unsupported pairs and coincident sphere
// centres give no hit with all-zero data. Fully pipelined: a new transaction is taken
// every cycle while the output is not stalled. Most of the pipeline depth is in the
// square-root pipe (one root bit per stage, 32 stages) and the normal divider (one
// quotient bit per stage, FRAC_BITS + 1 stages). m_tready low stalls the whole pipe.
// cfg_we writes point_margin: point radius in box and plane tests, push in plane tests.
module collision_pair_test_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [30:0]                      cfg_wdata,   // point_margin
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // a_x, a_y, a_z, b_x, b_y, b_z, a_scalar, b_scalar, half_x, half_y, half_z
    input  logic [colpt_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic [3:0]                       s_tuser,     // command
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // normal_x, normal_y, normal_z, push_depth
    output logic [colpt_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic [0:0]                       m_tuser      // hit
);
    import colpt_pkg::*;

    localparam logic signed [31:0] ONE_Q = 32'sd1 <<< FRAC_BITS;

    logic        en;
    logic [30:0] margin_reg;

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            margin_reg <= POINT_MARGIN_RST;
        end else if (cfg_we) begin
            margin_reg <= cfg_wdata;
        end
    end

    // ---------------- decode / pair ordering ----------------
    logic signed [31:0] in_a [0:2];
    logic signed [31:0] in_b [0:2];
    logic [30:0]        in_h [0:2];
    logic signed [31:0] in_sa;
    logic signed [31:0] in_sb;
    logic signed [31:0] margin_s;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            in_a[i] = s_tdata[32*i +: 32];
            in_b[i] = s_tdata[96 + 32*i +: 32];
            in_h[i] = s_tdata[256 + 31*i +: 31];
        end
    end
    assign in_sa    = s_tdata[223:192];
    assign in_sb    = s_tdata[255:224];
    assign margin_s = {1'b0, margin_reg};

    op_t                s1_op_next;
    logic signed [31:0] s1_u_next [0:2];
    logic signed [31:0] s1_v_next [0:2];
    logic signed [31:0] s1_r_next;
    logic signed [31:0] s1_d_next;

    always_comb begin
        s1_op_next = OP_NONE;
        s1_u_next  = in_a;
        s1_v_next  = in_b;
        s1_r_next  = in_sa;
        s1_d_next  = in_sb;
        unique case ({s_tuser[3:2], s_tuser[1:0]})
            {KIND_SPHERE, KIND_SPHERE}: begin
                s1_op_next = OP_SS;
            end
            {KIND_SPHERE, KIND_BOX}: begin
                s1_op_next = OP_BS;
                s1_u_next  = in_b;
                s1_v_next  = in_a;
            end
            {KIND_SPHERE, KIND_PLANE}: begin
                s1_op_next = OP_SPL;
                s1_u_next  = in_b;
                s1_v_next  = in_a;
            end
            {KIND_SPHERE, KIND_POINT}: begin
                s1_op_next = OP_SP;
                s1_u_next  = in_b;
                s1_v_next  = in_a;
            end
            {KIND_BOX, KIND_SPHERE}: begin
                s1_op_next = OP_BS;
                s1_r_next  = in_sb;
            end
            {KIND_BOX, KIND_PLANE}: begin
                s1_op_next = OP_BPL;
                s1_u_next  = in_b;
                s1_v_next  = in_a;
            end
            {KIND_BOX, KIND_POINT}: begin
                s1_op_next = OP_BS;
                s1_r_next  = margin_s;
            end
            {KIND_PLANE, KIND_SPHERE}: begin
                s1_op_next = OP_SPL;
                s1_r_next  = in_sb;
                s1_d_next  = in_sa;
            end
            {KIND_PLANE, KIND_BOX}: begin
                s1_op_next = OP_BPL;
                s1_d_next  = in_sa;
            end
            {KIND_PLANE, KIND_POINT}: begin
                s1_op_next = OP_PPL;
                s1_r_next  = margin_s;
                s1_d_next  = in_sa;
            end
            {KIND_POINT, KIND_SPHERE}: begin
                s1_op_next = OP_SP;
                s1_r_next  = in_sb;
            end
            {KIND_POINT, KIND_BOX}: begin
                s1_op_next = OP_BS;
                s1_u_next  = in_b;
                s1_v_next  = in_a;
                s1_r_next  = margin_s;
            end
            {KIND_POINT, KIND_PLANE}: begin
                s1_op_next = OP_PPL;
                s1_u_next  = in_b;
                s1_v_next  = in_a;
                s1_r_next  = margin_s;
            end
            default: begin
                s1_op_next = OP_NONE;
            end
        endcase
    end

    logic               s1_valid_reg;
    op_t                s1_op_reg;
    logic signed [31:0] s1_u_reg [0:2];
    logic signed [31:0] s1_v_reg [0:2];
    logic [30:0]        s1_h_reg [0:2];
    logic signed [31:0] s1_r_reg;
    logic signed [31:0] s1_d_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_op_reg <= s1_op_next;
            s1_u_reg  <= s1_u_next;
            s1_v_reg  <= s1_v_next;
            s1_h_reg  <= in_h;
            s1_r_reg  <= s1_r_next;
            s1_d_reg  <= s1_d_next;
        end
    end

    // ---------------- offsets, box excess, multiplier operands ----------------
    logic signed [32:0] diff_w [0:2];
    logic [32:0]        dabs_w [0:2];
    logic signed [33:0] d34_w  [0:2];
    logic signed [33:0] h34_w  [0:2];
    logic signed [33:0] e_w    [0:2];
    logic               eovf_w [0:2];
    logic               pos_w  [0:2];
    logic               neg_w  [0:2];
    logic [32:0]        uabs_w [0:2];
    logic [2:0][31:0]   face_w;
    logic [32:0]        s2_b1_next [0:2];
    logic [32:0]        s2_b2_next [0:2];
    logic [31:0]        s2_rabs_next;
    side_t              s2_side_next;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            diff_w[i] = $signed({s1_v_reg[i][31], s1_v_reg[i]})
                      - $signed({s1_u_reg[i][31], s1_u_reg[i]});
            dabs_w[i] = diff_w[i][32] ? 33'(-diff_w[i]) : diff_w[i];
            d34_w[i]  = {diff_w[i][32], diff_w[i]};
            h34_w[i]  = {3'b000, s1_h_reg[i]};
            if (d34_w[i] < -h34_w[i]) begin
                e_w[i] = -h34_w[i] - d34_w[i];
            end else if (d34_w[i] > h34_w[i]) begin
                e_w[i] = d34_w[i] - h34_w[i];
            end else begin
                e_w[i] = '0;
            end
            eovf_w[i] = e_w[i] > 34'sd2147483648;
            pos_w[i]  = d34_w[i] >= h34_w[i];
            neg_w[i]  = d34_w[i] <= -h34_w[i];
            uabs_w[i] = s1_u_reg[i][31] ? 33'(-$signed({s1_u_reg[i][31], s1_u_reg[i]}))
                                        : {1'b0, s1_u_reg[i]};
        end
    end

    // first face reached in order +x +y +z -x -y -z, else +y
    always_comb begin
        face_w = '0;
        priority if (pos_w[0]) begin
            face_w[0] = ONE_Q;
        end else if (pos_w[1]) begin
            face_w[1] = ONE_Q;
        end else if (pos_w[2]) begin
            face_w[2] = ONE_Q;
        end else if (neg_w[0]) begin
            face_w[0] = -ONE_Q;
        end else if (neg_w[1]) begin
            face_w[1] = -ONE_Q;
        end else if (neg_w[2]) begin
            face_w[2] = -ONE_Q;
        end else begin
            face_w[1] = ONE_Q;
        end
    end

    always_comb begin
        s2_rabs_next = s1_r_reg[31] ? 32'(-s1_r_reg) : s1_r_reg;
        s2_side_next.op   = s1_op_reg;
        s2_side_next.r    = s1_r_reg;
        s2_side_next.d    = s1_d_reg;
        s2_side_next.eovf = eovf_w[0] || eovf_w[1] || eovf_w[2];
        s2_side_next.face = face_w;
        for (int i = 0; i < 3; i++) begin
            s2_side_next.n[i]    = s1_u_reg[i];
            s2_side_next.diff[i] = diff_w[i];
        end
        unique case (s1_op_reg)
            OP_SS:   s2_side_next.rlim = $signed({s1_r_reg[31], s1_r_reg})
                                       + $signed({s1_d_reg[31], s1_d_reg});
            OP_SP:   s2_side_next.rlim = {s1_r_reg[31], s1_r_reg};
            OP_BS:   s2_side_next.rlim = {1'b0, s2_rabs_next};
            default: s2_side_next.rlim = '0;
        endcase
        for (int i = 0; i < 3; i++) begin
            unique case (s1_op_reg)
                OP_SS, OP_SP: begin
                    s2_b1_next[i] = dabs_w[i];
                    s2_b2_next[i] = dabs_w[i];
                end
                OP_BS: begin
                    s2_b1_next[i] = e_w[i][32:0];
                    s2_b2_next[i] = e_w[i][32:0];
                end
                OP_BPL: begin
                    s2_b1_next[i] = uabs_w[i];
                    s2_b2_next[i] = {2'b00, s1_h_reg[i]};
                end
                default: begin
                    s2_b1_next[i] = '0;
                    s2_b2_next[i] = '0;
                end
            endcase
        end
    end

    logic               s2_valid_reg;
    logic signed [31:0] s2_u_reg  [0:2];
    logic signed [31:0] s2_v_reg  [0:2];
    logic [32:0]        s2_b1_reg [0:2];
    logic [32:0]        s2_b2_reg [0:2];
    logic [31:0]        s2_rabs_reg;
    side_t              s2_side_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            s2_u_reg    <= s1_u_reg;
            s2_v_reg    <= s1_v_reg;
            s2_b1_reg   <= s2_b1_next;
            s2_b2_reg   <= s2_b2_next;
            s2_rabs_reg <= s2_rabs_next;
            s2_side_reg <= s2_side_next;
        end
    end

    // ---------------- products ----------------
    logic signed [63:0] s3_pa_next [0:2];
    logic [65:0]        s3_pb_next [0:2];
    logic [63:0]        s3_r2_next;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            s3_pa_next[i] = s2_u_reg[i] * s2_v_reg[i];
            s3_pb_next[i] = s2_b1_reg[i] * s2_b2_reg[i];
        end
        s3_r2_next = s2_rabs_reg * s2_rabs_reg;
    end

    logic               s3_valid_reg;
    logic signed [63:0] s3_pa_reg [0:2];
    logic [65:0]        s3_pb_reg [0:2];
    logic [63:0]        s3_r2_reg;
    side_t              s3_side_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            s3_pa_reg   <= s3_pa_next;
            s3_pb_reg   <= s3_pb_next;
            s3_r2_reg   <= s3_r2_next;
            s3_side_reg <= s2_side_reg;
        end
    end

    // ---------------- sums ----------------
    logic signed [65:0] s4_suma_next;
    logic [65:0]        s4_sumb_next;

    assign s4_suma_next = s3_pa_reg[0] + s3_pa_reg[1] + s3_pa_reg[2];
    assign s4_sumb_next = s3_pb_reg[0] + s3_pb_reg[1] + s3_pb_reg[2];

    logic               s4_valid_reg;
    logic signed [65:0] s4_suma_reg;
    logic [65:0]        s4_sumb_reg;
    logic [63:0]        s4_r2_reg;
    side_t              s4_side_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            s4_suma_reg <= s4_suma_next;
            s4_sumb_reg <= s4_sumb_next;
            s4_r2_reg   <= s3_r2_reg;
            s4_side_reg <= s3_side_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end else if (en) begin
            s1_valid_reg <= s_tvalid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    // ---------------- plane distances, box radius, early decisions ----------------
    logic signed [67:0] dd_w;
    logic signed [67:0] rad_w;
    logic signed [67:0] r68_w;
    ctx_t               sq_ctx_in;

    always_comb begin
        dd_w  = ($signed({{2{s4_suma_reg[65]}}, s4_suma_reg}) >>> FRAC_BITS)
              - $signed({{36{s4_side_reg.d[31]}}, s4_side_reg.d});
        rad_w = $signed({2'b00, s4_sumb_reg} >> FRAC_BITS);
        r68_w = $signed({{36{s4_side_reg.r[31]}}, s4_side_reg.r});

        sq_ctx_in.op   = s4_side_reg.op;
        sq_ctx_in.diff = s4_side_reg.diff;
        sq_ctx_in.rlim = s4_side_reg.rlim;
        sq_ctx_in.n    = s4_side_reg.n;
        sq_ctx_in.hit  = 1'b0;
        sq_ctx_in.push = '0;
        unique case (s4_side_reg.op)
            OP_SPL: begin
                sq_ctx_in.hit  = dd_w < r68_w;
                sq_ctx_in.push = sat32(r68_w - dd_w);
            end
            OP_PPL: begin
                sq_ctx_in.hit  = dd_w < r68_w;
                sq_ctx_in.push = s4_side_reg.r;
            end
            OP_BPL: begin
                sq_ctx_in.hit  = dd_w < rad_w;
                sq_ctx_in.push = sat32(rad_w - dd_w);
            end
            OP_SS, OP_SP: begin
                sq_ctx_in.hit = s4_sumb_reg[65:64] == 2'b00;
            end
            OP_BS: begin
                sq_ctx_in.hit = !s4_side_reg.eovf && (s4_sumb_reg <= {2'b00, s4_r2_reg});
                sq_ctx_in.n   = s4_side_reg.face;
            end
            default: begin
                sq_ctx_in.hit = 1'b0;
            end
        endcase
    end

    logic        sq_valid;
    logic [31:0] sq_root;
    ctx_t        sq_ctx;

    colpt_isqrt u_isqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s4_valid_reg),
        .in_val    (s4_sumb_reg[63:0]),
        .in_ctx    (sq_ctx_in),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_ctx   (sq_ctx)
    );

    // ---------------- decisions that need the length ----------------
    ctx_t               dv_ctx_in;
    logic signed [67:0] lim68_w;
    logic signed [67:0] len68_w;

    always_comb begin
        lim68_w   = $signed({{35{sq_ctx.rlim[32]}}, sq_ctx.rlim});
        len68_w   = $signed({36'd0, sq_root});
        dv_ctx_in = sq_ctx;
        unique case (sq_ctx.op)
            OP_SS: begin
                dv_ctx_in.hit  = sq_ctx.hit && (sq_root != '0) && (len68_w < lim68_w);
                dv_ctx_in.push = sat32(lim68_w - len68_w);
            end
            OP_SP: begin
                dv_ctx_in.hit  = sq_ctx.hit && (sq_root != '0) && (len68_w < lim68_w);
                dv_ctx_in.push = '0;
            end
            OP_BS: begin
                dv_ctx_in.push = sat32(lim68_w - len68_w);
            end
            default: begin
                dv_ctx_in.push = sq_ctx.push;
            end
        endcase
    end

    logic             dv_valid;
    ctx_t             dv_ctx;
    logic [2:0][31:0] dv_q;

    colpt_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (sq_valid),
        .in_len    (sq_root),
        .in_ctx    (dv_ctx_in),
        .out_valid (dv_valid),
        .out_ctx   (dv_ctx),
        .out_q     (dv_q)
    );

    // ---------------- output register ----------------
    logic [M_TDATA_W-1:0] m_tdata_next;
    logic [2:0][31:0]     nrm_w;
    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic                 m_hit_reg;

    always_comb begin
        if (dv_ctx.op == OP_SS || dv_ctx.op == OP_SP) begin
            nrm_w = dv_q;
        end else begin
            nrm_w = dv_ctx.n;
        end
        if (dv_ctx.hit) begin
            m_tdata_next = {dv_ctx.push, nrm_w[2], nrm_w[1], nrm_w[0]};
        end else begin
            m_tdata_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= dv_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata_reg <= m_tdata_next;
            m_hit_reg   <= dv_ctx.hit;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_hit_reg;

endmodule

[rtl/colpt_isqrt.sv]
module colpt_isqrt (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [63:0]       in_val,
    input  colpt_pkg::ctx_t   in_ctx,
    output logic              out_valid,
    output logic [31:0]       out_root,
    output colpt_pkg::ctx_t   out_ctx
);
    import colpt_pkg::*;

    localparam int STEPS = 32;

    logic [STEPS:0] valid_reg;
    logic [63:0]    val_reg  [0:STEPS];
    logic [33:0]    rem_reg  [0:STEPS];
    logic [31:0]    root_reg [0:STEPS];
    ctx_t           ctx_reg  [0:STEPS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[STEPS-1:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            val_reg[0]  <= in_val;
            rem_reg[0]  <= '0;
            root_reg[0] <= '0;
            ctx_reg[0]  <= in_ctx;
        end
    end

    // one root bit per stage, two radicand bits shifted in
    for (genvar k = 1; k <= STEPS; k++) begin : g_step
        logic [35:0] cur;
        logic [35:0] trial;
        logic [35:0] sub;
        logic        ge;
        logic [33:0] rem_next;
        logic [31:0] root_next;

        always_comb begin
            cur       = {rem_reg[k-1], val_reg[k-1][63:62]};
            trial     = {2'b00, root_reg[k-1], 2'b01};
            sub       = cur - trial;
            ge        = cur >= trial;
            rem_next  = ge ? sub[33:0] : cur[33:0];
            root_next = {root_reg[k-1][30:0], ge};
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                val_reg[k]  <= {val_reg[k-1][61:0], 2'b00};
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
                ctx_reg[k]  <= ctx_reg[k-1];
            end
        end
    end

    assign out_valid = valid_reg[STEPS];
    assign out_root  = root_reg[STEPS];
    assign out_ctx   = ctx_reg[STEPS];

endmodule

[rtl/colpt_div.sv]
module colpt_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [31:0]       in_len,
    input  colpt_pkg::ctx_t   in_ctx,
    output logic              out_valid,
    output colpt_pkg::ctx_t   out_ctx,
    output logic [2:0][31:0]  out_q
);
    import colpt_pkg::*;

    localparam int QW = FRAC_BITS + 1;

    logic [FRAC_BITS:0] valid_reg;
    logic [31:0]        len_reg [0:FRAC_BITS];
    logic [31:0]        rem_reg [0:FRAC_BITS][0:2];
    logic [QW-1:0]      q_reg   [0:FRAC_BITS][0:2];
    ctx_t               ctx_reg [0:FRAC_BITS];

    logic [32:0]        mag0    [0:2];
    logic [32:0]        sub0    [0:2];
    logic               ge0     [0:2];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            mag0[i] = in_ctx.diff[i][32] ? 33'(-$signed(in_ctx.diff[i])) : in_ctx.diff[i];
            sub0[i] = mag0[i] - {1'b0, in_len};
            ge0[i]  = mag0[i] >= {1'b0, in_len};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[FRAC_BITS-1:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            len_reg[0] <= in_len;
            ctx_reg[0] <= in_ctx;
            for (int i = 0; i < 3; i++) begin
                rem_reg[0][i] <= ge0[i] ? sub0[i][31:0] : mag0[i][31:0];
                q_reg[0][i]   <= {{(QW-1){1'b0}}, ge0[i]};
            end
        end
    end

    for (genvar k = 1; k <= FRAC_BITS; k++) begin : g_step
        logic [32:0] rem2 [0:2];
        logic [32:0] sub  [0:2];
        logic        ge   [0:2];

        always_comb begin
            for (int i = 0; i < 3; i++) begin
                rem2[i] = {rem_reg[k-1][i], 1'b0};
                sub[i]  = rem2[i] - {1'b0, len_reg[k-1]};
                ge[i]   = rem2[i] >= {1'b0, len_reg[k-1]};
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                len_reg[k] <= len_reg[k-1];
                ctx_reg[k] <= ctx_reg[k-1];
                for (int i = 0; i < 3; i++) begin
                    rem_reg[k][i] <= ge[i] ? sub[i][31:0] : rem2[i][31:0];
                    q_reg[k][i]   <= {q_reg[k-1][i][QW-2:0], ge[i]};
                end
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (ctx_reg[FRAC_BITS].diff[i][32]) begin
                out_q[i] = 32'(-$signed({1'b0, q_reg[FRAC_BITS][i]}));
            end else begin
                out_q[i] = 32'(q_reg[FRAC_BITS][i]);
            end
        end
    end

    assign out_valid = valid_reg[FRAC_BITS];
    assign out_ctx   = ctx_reg[FRAC_BITS];

endmodule

[rtl/colpt_checker.sv]
module colpt_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [127:0] m_tdata,
    input logic [0:0]   m_tuser
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output transaction dropped or changed under backpressure");

    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata == '0)
        else $error("miss carries nonzero normal or push");

    a_push_nonneg: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !m_tdata[127])
        else $error("negative push depth");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid || m_tready |-> s_tready)
        else $error("input stalled while output stage can advance");

endmodule

bind collision_pair_test_unit colpt_checker u_colpt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
